/* hw/rtl/wots_chain_verify_assert.svh */
// Assertion macros shared by the WOTS chain verify RTL.
// Depends on nothing; included by modules that assert.
`ifndef WOTS_CHAIN_VERIFY_ASSERT_SVH
`define WOTS_CHAIN_VERIFY_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define WCV_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define WCV_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* hw/rtl/wcv_pkg.sv */
// Package for the WOTS chain verify block: SHA-256 constants, types, round helpers.
// Used by wcv_sha_core and wots_chain_verify.
package wcv_pkg;
	localparam int CHAIN_COUNT = 67;
	localparam int MSG_DIGITS  = 64;
	localparam int DIGIT_BASE  = 16;
	localparam logic [3:0] DIGIT_MAX = 4'hf;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD_HASH, ST_LOAD_SUM, ST_CHAIN_START, ST_CHAIN_HASH, ST_OUT
	} wcv_state_t;

	typedef struct packed {
		logic start;
		logic [511:0] block;
	} sha_req_t;

	typedef struct packed {
		logic done;
		logic [255:0] digest;
	} sha_rsp_t;

	localparam logic [255:0] H_INIT = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	function automatic logic [31:0] k_const(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction
endpackage

/* hw/rtl/wots_chain_verify.sv */
// Top level of the WOTS+ (w=16) chain completion block.
// Depends on wcv_pkg and wcv_sha_core.
//
// Usage:
//  - Input stream s_axis: tuser = req_type, tdata = {data_lo, data_hi}
//    (data_hi in bits 63:0). req_type 0 loads a 16-byte context; 1 gives
//    the next signature chain element.
//  - Output stream m_axis: tdata = end_hi, end_lo, chain_number (bits 134:128),
//    zero padded to 136 bits; tlast = last (set on chain 66).
//  - One transaction is processed at a time; s_axis_tready is low while busy.
//  - Load: one SHA-256 compression of the context plus a walk writing the
//    67 digits into the digit store; no result.
//  - Chain item: the element is hashed 15 - digit times, one compression
//    at a time on the single shared round unit, then the result is offered.
//  - Chain items before a load or after chain 66 are dropped with no result.
//  - The result waits in an output register until m_axis_tready; the block
//    takes no new input until it is delivered.
//  - Reset clears the sequencer, chain counter and loaded flag; the digit
//    store holds garbage until the first load.
module wots_chain_verify
	import wcv_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // data_hi[63:0], data_lo[127:64]
	input  logic         s_axis_tuser,  // req_type
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [135:0] m_axis_tdata,  // end_hi[63:0], end_lo[127:64], chain_number[134:128]
	output logic         m_axis_tlast   // last
);
	`include "wots_chain_verify_assert.svh"

	wcv_state_t   state_q, state_d;
	logic [127:0] val_q;
	logic [255:0] dig_q;          // load digest, consumed one nibble per cycle
	logic [6:0]   chain_q;
	logic         loaded_q;
	logic [3:0]   j_q;
	logic [6:0]   idx_q;
	logic [9:0]   csum_q;
	logic [3:0]   digit_mem [CHAIN_COUNT];
	logic [3:0]   rd_digit_q;
	sha_req_t     sreq;
	sha_rsp_t     srsp;
	logic         acc;
	logic         hash_go_q;

	assign acc = s_axis_tvalid && s_axis_tready;

	wcv_sha_core u_sha (.clk(clk), .arst_n(arst_n), .req(sreq), .rsp(srsp));

	// block builder: 16-byte context or 17-byte (x || j)
	always_comb begin
		sreq.block = '0;
		sreq.start = hash_go_q && (state_q == ST_LOAD_HASH || state_q == ST_CHAIN_HASH);
		if (state_q == ST_LOAD_HASH) begin
			sreq.block[511:384] = val_q;
			sreq.block[383:376] = 8'h80;
			sreq.block[63:0]    = 64'd128;
		end else begin
			sreq.block[511:384] = val_q;
			sreq.block[383:376] = {4'h0, j_q};
			sreq.block[375:368] = 8'h80;
			sreq.block[63:0]    = 64'd136;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		s_axis_tready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (!s_axis_tuser) state_d = ST_LOAD_HASH;
					else if (loaded_q && chain_q < 7'(CHAIN_COUNT)) state_d = ST_CHAIN_START;
				end
			end
			ST_LOAD_HASH: begin
				if (srsp.done) state_d = ST_LOAD_SUM;
			end
			ST_LOAD_SUM: begin
				if (idx_q == 7'(CHAIN_COUNT)) state_d = ST_IDLE;
			end
			ST_CHAIN_START: begin
				if (rd_digit_q == DIGIT_MAX) state_d = ST_OUT;
				else state_d = ST_CHAIN_HASH;
			end
			ST_CHAIN_HASH: begin
				if (srsp.done && j_q == DIGIT_MAX - 4'd1) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (m_axis_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q   <= '0;
			loaded_q  <= 1'b0;
			hash_go_q <= 1'b0;
		end else begin
			hash_go_q <= 1'b0;
			if (acc && !s_axis_tuser) begin
				chain_q   <= '0;
				loaded_q  <= 1'b1;
				hash_go_q <= 1'b1;
			end
			if (state_q == ST_CHAIN_START && rd_digit_q != DIGIT_MAX) hash_go_q <= 1'b1;
			if (state_q == ST_CHAIN_HASH && srsp.done && j_q != DIGIT_MAX - 4'd1)
				hash_go_q <= 1'b1;
			if (state_q == ST_OUT && m_axis_tready) chain_q <= chain_q + 7'd1;
		end
	end

	// datapath and digit store
	always_ff @(posedge clk) begin
		rd_digit_q <= digit_mem[chain_q];
		if (acc) begin
			val_q <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
			idx_q <= '0;
			csum_q <= '0;
		end
		if (state_q == ST_LOAD_HASH && srsp.done) dig_q <= srsp.digest;
		if (state_q == ST_LOAD_SUM) begin
			// message digits first, then the three checksum digits, low first
			if (idx_q < 7'(MSG_DIGITS)) begin
				digit_mem[idx_q] <= dig_q[255:252];
				csum_q <= csum_q + 10'(DIGIT_MAX - dig_q[255:252]);
				dig_q  <= {dig_q[251:0], 4'h0};
			end else if (idx_q < 7'(CHAIN_COUNT)) begin
				digit_mem[idx_q] <= csum_q[3:0];
				csum_q <= {4'h0, csum_q[9:4]};
			end
			idx_q <= idx_q + 7'd1;
		end
		if (state_q == ST_CHAIN_START) j_q <= rd_digit_q;
		if (state_q == ST_CHAIN_HASH && srsp.done) begin
			val_q <= srsp.digest[255:128];
			j_q   <= j_q + 4'd1;
		end
	end

	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = {1'b0, chain_q, val_q[63:0], val_q[127:64]};
	assign m_axis_tlast  = (chain_q == 7'(CHAIN_COUNT - 1));

	`WCV_ASSERT_IMP(a_out_chain_range, m_axis_tvalid, chain_q < 7'(CHAIN_COUNT),
		"top: result for chain out of range")
	`WCV_ASSERT_IMP(a_out_loaded, m_axis_tvalid, loaded_q, "top: result before load")
	`WCV_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata), "top: stalled result changed")
endmodule

/* hw/rtl/wcv_sha_core.sv */
// Iterative SHA-256 compression of one padded block, one round per cycle.
// Depends on wcv_pkg.
module wcv_sha_core
	import wcv_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  sha_req_t req,
	output sha_rsp_t rsp
);
	`include "wots_chain_verify_assert.svh"

	logic          busy_q;
	logic [5:0]    rnd_q;
	logic [511:0]  w_q;     // 16-word schedule window, w[t] in top word
	logic [255:0]  st_q;    // a..h, a in top word
	logic          done_q;

	logic [31:0] a, b, c, d, e, f, g, h, t1, t2, wt, w1, w14, w9, w0, s0, s1, wn;

	always_comb begin
		{a, b, c, d, e, f, g, h} = st_q;
		wt  = w_q[511:480];
		w0  = w_q[511:480];
		w1  = w_q[479:448];
		w9  = w_q[223:192];
		w14 = w_q[63:32];
		s0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
		s1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
		wn  = w0 + s0 + w9 + s1;
		t1  = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
			+ k_const(rnd_q) + wt;
		t2  = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			w_q  <= req.block;
			st_q <= H_INIT;
		end else if (busy_q) begin
			w_q  <= {w_q[479:0], wn};
			st_q <= {t1 + t2, a, b, c, d + t1, e, f, g};
		end
	end

	// final feed-forward add is combinational on done
	always_comb begin
		rsp.done = done_q;
		for (int i = 0; i < 8; i++)
			rsp.digest[i*32 +: 32] = st_q[i*32 +: 32] + H_INIT[i*32 +: 32];
	end

	`WCV_ASSERT_NXT(a_done_after_last, busy_q && rnd_q == 6'd63, done_q && !busy_q,
		"sha core: no done after round 63")
	`WCV_ASSERT_IMP(a_done_idle, done_q, !busy_q, "sha core: done while busy")
	`WCV_ASSERT_NXT(a_start_busy, req.start && !busy_q, busy_q, "sha core: start ignored")
endmodule
